@@ hw/rtl/lcdseq_pkg.sv @@
package lcdseq_pkg;

  typedef enum logic [2:0] {
    CMD_WRITE_AT     = 3'd0,
    CMD_WRITE_CURSOR = 3'd1,
    CMD_CLEAR        = 3'd2,
    CMD_HOME         = 3'd3,
    CMD_INIT         = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    REG_FUNCTION_SET = 2'd0,
    REG_SHIFT_SET    = 2'd1,
    REG_DISPLAY_SET  = 2'd2,
    REG_ENTRY_SET    = 2'd3
  } reg_idx_t;

  localparam logic [7:0] FUNCTION_SET_RST = 8'h28;
  localparam logic [7:0] SHIFT_SET_RST    = 8'h14;
  localparam logic [7:0] DISPLAY_SET_RST  = 8'h0C;
  localparam logic [7:0] ENTRY_SET_RST    = 8'h06;

  localparam int          EIGHT_BIT_POS  = 4;
  localparam logic [6:0]  LINE0_END      = 7'h0F;
  localparam logic [6:0]  LINE1_START    = 7'h40;
  localparam logic [6:0]  LINE1_END      = 7'h4F;
  localparam logic [7:0]  INSTR_CLEAR    = 8'h01;
  localparam logic [7:0]  INSTR_HOME     = 8'h02;

  typedef logic [5:0] uc_addr_t;

  // Entry points and byte groups of the microprogram
  localparam uc_addr_t UC_WRITE = 6'd0;
  localparam uc_addr_t UC_CHAR  = 6'd5;
  localparam uc_addr_t UC_CTRL  = 6'd10;
  localparam uc_addr_t UC_INIT  = 6'd15;
  localparam uc_addr_t UC_FUNC  = 6'd24;
  localparam uc_addr_t UC_SHIFT = 6'd29;
  localparam uc_addr_t UC_DISP  = 6'd34;
  localparam uc_addr_t UC_ENTRY = 6'd39;
  localparam uc_addr_t UC_CLEAR = 6'd44;
  localparam uc_addr_t UC_END   = 6'd49;
  localparam uc_addr_t UC_IDLE_OFS = 6'd4;

  typedef enum logic [1:0] {
    NIB_CONST,
    NIB_HIGH,
    NIB_LOW
  } nib_sel_t;

  typedef enum logic [2:0] {
    HOLD_30,
    HOLD_160,
    HOLD_5000,
    HOLD_40000,
    HOLD_80,
    HOLD_117,
    HOLD_2080
  } hold_sel_t;

  typedef enum logic [2:0] {
    BYTE_ADDR,
    BYTE_CHAR,
    BYTE_CMD,
    BYTE_FUNC,
    BYTE_SHIFT,
    BYTE_DISP,
    BYTE_ENTRY,
    BYTE_CLEAR
  } byte_sel_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_SKIP8,
    SEQ_END
  } seq_t;

  typedef struct packed {
    nib_sel_t  nib_sel;
    logic [3:0] nib;
    logic      rs;
    logic      en;
    hold_sel_t hold;
    byte_sel_t byte_sel;
    seq_t      seq;
    uc_addr_t  target;
  } uc_word_t;

  function automatic logic [15:0] hold_value(hold_sel_t h);
    logic [15:0] v;
    unique case (h)
      HOLD_30:    v = 16'd30;
      HOLD_160:   v = 16'd160;
      HOLD_5000:  v = 16'd5000;
      HOLD_40000: v = 16'd40000;
      HOLD_80:    v = 16'd80;
      HOLD_117:   v = 16'd117;
      HOLD_2080:  v = 16'd2080;
      default:    v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic uc_word_t const_step(logic [3:0] nib, logic en, hold_sel_t hold);
    uc_word_t w;
    w.nib_sel  = NIB_CONST;
    w.nib      = nib;
    w.rs       = 1'b0;
    w.en       = en;
    w.hold     = hold;
    w.byte_sel = BYTE_CLEAR;
    w.seq      = SEQ_NEXT;
    w.target   = UC_WRITE;
    return w;
  endfunction

  // One byte: high nibble strobe, low nibble strobe (skipped in eight-bit mode), idle
  function automatic uc_word_t byte_step(logic [2:0] phase, byte_sel_t bsel, logic rs,
                                         hold_sel_t idle, logic fin, uc_addr_t base);
    uc_word_t w;
    w.nib_sel  = NIB_HIGH;
    w.nib      = 4'd0;
    w.rs       = rs;
    w.en       = 1'b1;
    w.hold     = HOLD_30;
    w.byte_sel = bsel;
    w.seq      = SEQ_NEXT;
    w.target   = base + UC_IDLE_OFS;
    unique case (phase)
      3'd0: begin
        w.nib_sel = NIB_HIGH;
        w.en      = 1'b1;
      end
      3'd1: begin
        w.nib_sel = NIB_HIGH;
        w.en      = 1'b0;
        w.seq     = SEQ_SKIP8;
      end
      3'd2: begin
        w.nib_sel = NIB_LOW;
        w.en      = 1'b1;
      end
      3'd3: begin
        w.nib_sel = NIB_LOW;
        w.en      = 1'b0;
      end
      default: begin
        w.nib_sel = NIB_CONST;
        w.en      = 1'b0;
        w.hold    = idle;
        w.seq     = fin ? SEQ_END : SEQ_NEXT;
      end
    endcase
    return w;
  endfunction

  function automatic uc_word_t uc_rom(uc_addr_t addr);
    uc_word_t w;
    uc_addr_t d;
    d = '0;
    priority if (addr < UC_CHAR) begin
      d = addr - UC_WRITE;
      w = byte_step(d[2:0], BYTE_ADDR, 1'b0, HOLD_117, 1'b0, UC_WRITE);
    end else if (addr < UC_CTRL) begin
      d = addr - UC_CHAR;
      w = byte_step(d[2:0], BYTE_CHAR, 1'b1, HOLD_117, 1'b1, UC_CHAR);
    end else if (addr < UC_INIT) begin
      d = addr - UC_CTRL;
      w = byte_step(d[2:0], BYTE_CMD, 1'b0, HOLD_2080, 1'b1, UC_CTRL);
    end else if (addr < UC_FUNC) begin
      d = addr - UC_INIT;
      unique case (d[3:0])
        4'd0:                w = const_step(4'd0, 1'b0, HOLD_40000);
        4'd1:                w = const_step(4'd3, 1'b0, HOLD_5000);
        4'd2, 4'd4, 4'd6:    w = const_step(4'd3, 1'b1, HOLD_30);
        4'd3, 4'd5, 4'd7:    w = const_step(4'd3, 1'b0, HOLD_160);
        default:             w = const_step(4'd2, 1'b1, HOLD_30);
      endcase
    end else if (addr < UC_SHIFT) begin
      d = addr - UC_FUNC;
      w = byte_step(d[2:0], BYTE_FUNC, 1'b0, HOLD_80, 1'b0, UC_FUNC);
    end else if (addr < UC_DISP) begin
      d = addr - UC_SHIFT;
      w = byte_step(d[2:0], BYTE_SHIFT, 1'b0, HOLD_80, 1'b0, UC_SHIFT);
    end else if (addr < UC_ENTRY) begin
      d = addr - UC_DISP;
      w = byte_step(d[2:0], BYTE_DISP, 1'b0, HOLD_80, 1'b0, UC_DISP);
    end else if (addr < UC_CLEAR) begin
      d = addr - UC_ENTRY;
      w = byte_step(d[2:0], BYTE_ENTRY, 1'b0, HOLD_80, 1'b0, UC_ENTRY);
    end else if (addr < UC_END) begin
      d = addr - UC_CLEAR;
      w = byte_step(d[2:0], BYTE_CLEAR, 1'b0, HOLD_2080, 1'b1, UC_CLEAR);
    end else begin
      // parked past the end of the program while idle
      w = const_step(4'd0, 1'b0, HOLD_80);
      w.seq = SEQ_END;
    end
    return w;
  endfunction

endpackage

@@ hw/rtl/char_lcd_nibble_write_sequencer_core.sv @@
// A command transfer loads the microcode step counter and sets busy; the first segment
// is then registered onto out_*. One segment per cycle while out_tready does not stall
// the output; write commands give 10 segments (6 in eight-bit mode), clear/home 5 (3),
// init 34 (24). The next command is taken once the last segment of the previous one
// is registered. Unused command codes are taken and produce no segments.
// Synchronous active-low reset: idle, cursor 0, setting registers at defaults.
module char_lcd_nibble_write_sequencer_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [15:0]            in_tdata,   // address[6:0], char_code[14:7], 0
  input  logic [2:0]             in_tuser,   // command[2:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [23:0]            out_tdata,  // data_nibble[3:0], reg_select[4],
                                             // read_write[5], enable[6], hold_us[22:7], 0
  output logic                   out_tlast,  // last
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  lcdseq_pkg::reg_idx_t   cfg_index,
  input  logic [7:0]             cfg_data
);
  import lcdseq_pkg::*;

  logic        busy_r;
  uc_addr_t    pc_r, pc_nxt;
  logic [6:0]  cursor_r, cursor_nxt;
  logic [6:0]  addr_r;
  logic [7:0]  char_r;
  logic        home_r;
  logic [7:0]  func_r, shift_r, disp_r, entry_r;
  logic        out_valid_r;
  logic [22:0] seg_r;
  logic        last_r;

  uc_word_t    uw;
  logic [7:0]  byte_val;
  logic [3:0]  nib_val;
  logic        eight_bit;
  logic        adv;
  logic        in_xfer;
  cmd_t        cmd_in;
  logic [6:0]  addr_in;
  logic [6:0]  loc;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !busy_r;
  assign in_xfer    = in_tvalid && !busy_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, seg_r};
  assign out_tlast  = last_r;
  assign cmd_in     = cmd_t'(in_tuser);
  assign addr_in    = in_tdata[6:0];
  assign eight_bit  = func_r[EIGHT_BIT_POS];
  assign adv        = busy_r && (!out_valid_r || out_tready);

  // Wrap the cursor from the end of line 0 to line 1, and past line 1 back to 0
  always_comb begin
    priority if (cursor_r > LINE0_END && cursor_r < LINE1_START) begin
      loc = LINE1_START;
    end else if (cursor_r > LINE1_END) begin
      loc = 7'd0;
    end else begin
      loc = cursor_r;
    end
  end

  always_comb begin
    cursor_nxt = cursor_r;
    if (in_xfer) begin
      unique case (cmd_in)
        CMD_WRITE_AT:     cursor_nxt = addr_in + 7'd1;
        CMD_WRITE_CURSOR: cursor_nxt = loc + 7'd1;
        CMD_CLEAR, CMD_HOME, CMD_INIT: cursor_nxt = 7'd0;
        default:          cursor_nxt = cursor_r;
      endcase
    end
  end

  always_comb begin
    uw = uc_rom(pc_r);
    unique case (uw.byte_sel)
      BYTE_ADDR:  byte_val = {1'b1, addr_r};
      BYTE_CHAR:  byte_val = char_r;
      BYTE_CMD:   byte_val = home_r ? INSTR_HOME : INSTR_CLEAR;
      BYTE_FUNC:  byte_val = func_r;
      BYTE_SHIFT: byte_val = shift_r;
      BYTE_DISP:  byte_val = disp_r;
      BYTE_ENTRY: byte_val = entry_r;
      default:    byte_val = INSTR_CLEAR;
    endcase
    unique case (uw.nib_sel)
      NIB_HIGH: nib_val = byte_val[7:4];
      NIB_LOW:  nib_val = byte_val[3:0];
      default:  nib_val = uw.nib;
    endcase
    // advance, or jump past the low nibble in eight-bit mode
    if (uw.seq == SEQ_SKIP8 && eight_bit) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = pc_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= UC_WRITE;
      cursor_r    <= 7'd0;
      out_valid_r <= 1'b0;
      func_r      <= FUNCTION_SET_RST;
      shift_r     <= SHIFT_SET_RST;
      disp_r      <= DISPLAY_SET_RST;
      entry_r     <= ENTRY_SET_RST;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_FUNCTION_SET: func_r  <= cfg_data;
          REG_SHIFT_SET:    shift_r <= cfg_data;
          REG_DISPLAY_SET:  disp_r  <= cfg_data;
          default:          entry_r <= cfg_data;
        endcase
      end

      cursor_r <= cursor_nxt;

      if (out_valid_r && out_tready && !adv) begin
        out_valid_r <= 1'b0;
      end

      if (in_xfer) begin
        addr_r <= (cmd_in == CMD_WRITE_AT) ? addr_in : loc;
        char_r <= in_tdata[14:7];
        home_r <= (cmd_in == CMD_HOME);
        unique case (cmd_in)
          CMD_WRITE_AT, CMD_WRITE_CURSOR: begin
            busy_r <= 1'b1;
            pc_r   <= UC_WRITE;
          end
          CMD_CLEAR, CMD_HOME: begin
            busy_r <= 1'b1;
            pc_r   <= UC_CTRL;
          end
          CMD_INIT: begin
            busy_r <= 1'b1;
            pc_r   <= UC_INIT;
          end
          default: busy_r <= 1'b0;
        endcase
      end

      if (adv) begin
        out_valid_r <= 1'b1;
        last_r      <= (uw.seq == SEQ_END);
        seg_r       <= {hold_value(uw.hold), uw.en, 1'b0, uw.rs, nib_val};
        if (uw.seq == SEQ_END) begin
          busy_r <= 1'b0;
        end
        pc_r <= pc_nxt;
      end
    end
  end

endmodule

@@ tb/sv/tb_char_lcd_nibble_write_sequencer_core.sv @@
module tb_char_lcd_nibble_write_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lcdseq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_REPORTS    = 40;

  localparam logic [15:0] STROBE_US     = 16'd30;
  localparam logic [15:0] WAKE_GAP_US   = 16'd160;
  localparam logic [15:0] BYTE_IDLE_US  = 16'd80;
  localparam logic [15:0] CHAR_WAIT_US  = 16'd37;
  localparam logic [15:0] CLEAR_WAIT_US = 16'd2000;
  localparam logic [15:0] POWER_WAIT_US = 16'd40000;
  localparam logic [15:0] WAKE_SETUP_US = 16'd5000;

  localparam logic [7:0] LCD_CLEAR     = 8'h01;
  localparam logic [7:0] LCD_HOME      = 8'h02;
  localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
  localparam logic [6:0] ROW0_LAST     = 7'h0F;
  localparam logic [6:0] ROW1_FIRST    = 7'h40;
  localparam logic [6:0] ROW1_LAST     = 7'h4F;
  localparam int         EIGHT_BIT_BIT = 4;

  // Codes past CMD_INIT that the block takes and drops
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [3:0]  nib;
    logic        rs;
    logic        rw;
    logic        en;
    logic [15:0] hold;
    logic        last;
  } lcd_seg_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // address[6:0], char_code[14:7], 0
  logic [2:0]  in_tuser = '0;   // command[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // data_nibble[3:0], reg_select[4], read_write[5],
                                // enable[6], hold_us[22:7], 0
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  reg_idx_t    cfg_index = REG_FUNCTION_SET;
  logic [7:0]  cfg_data = '0;

  // Predicted pin segments, oldest first
  lcd_seg_t    seg_q[$];

  logic [7:0]  fs_word = FUNCTION_SET_RST;
  logic [7:0]  sh_word = SHIFT_SET_RST;
  logic [7:0]  dp_word = DISPLAY_SET_RST;
  logic [7:0]  em_word = ENTRY_SET_RST;
  logic [6:0]  cursor_addr = '0;

  bit          calm = 1'b0;
  bit          rx_hold_req = 1'b0;
  bit          rx_holding = 1'b0;

  int          n_errors = 0;
  int          n_cmds = 0;
  int          n_ignored = 0;
  int          n_inits = 0;
  int          n_segments = 0;
  int          n_loads = 0;
  int          n_in_stalls = 0;
  int          idle_cycles = 0;

  char_lcd_nibble_write_sequencer_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (n_errors < MAX_REPORTS) begin
      $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    n_errors++;
  endtask

  // ---------------- segment predictor ----------------

  task automatic push_seg(input logic [3:0] nib, input logic rs, input logic en,
                          input logic [15:0] hold, input logic fin);
    lcd_seg_t s;
    s.nib  = nib;
    s.rs   = rs;
    s.rw   = 1'b0;
    s.en   = en;
    s.hold = hold;
    s.last = fin;
    seg_q.push_back(s);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic rs, input logic [15:0] wait_us,
                           input logic fin);
    push_seg(b[7:4], rs, 1'b1, STROBE_US, 1'b0);
    push_seg(b[7:4], rs, 1'b0, STROBE_US, 1'b0);
    // eight-bit mode drops the low nibble
    if (!fs_word[EIGHT_BIT_BIT]) begin
      push_seg(b[3:0], rs, 1'b1, STROBE_US, 1'b0);
      push_seg(b[3:0], rs, 1'b0, STROBE_US, 1'b0);
    end
    push_seg(4'h0, rs, 1'b0, BYTE_IDLE_US + wait_us, fin);
  endtask

  task automatic push_char_write(input logic [6:0] adr, input logic [7:0] chr);
    push_byte(LCD_SET_DDRAM | {1'b0, adr}, 1'b0, CHAR_WAIT_US, 1'b0);
    push_byte(chr, 1'b1, CHAR_WAIT_US, 1'b1);
    cursor_addr = adr + 7'd1;
  endtask

  task automatic predict_segments(input logic [2:0] cmd, input logic [6:0] adr,
                                  input logic [7:0] chr);
    logic [6:0] loc;
    loc = cursor_addr;
    case (cmd_t'(cmd))
      CMD_WRITE_AT: push_char_write(adr, chr);
      CMD_WRITE_CURSOR: begin
        // wrap: end of row 0 jumps to row 1, past row 1 back to home
        if (loc > ROW0_LAST && loc < ROW1_FIRST) loc = ROW1_FIRST;
        else if (loc > ROW1_LAST) loc = 7'd0;
        push_char_write(loc, chr);
      end
      CMD_CLEAR, CMD_HOME: begin
        push_byte((cmd == CMD_CLEAR) ? LCD_CLEAR : LCD_HOME, 1'b0, CLEAR_WAIT_US, 1'b1);
        cursor_addr = '0;
      end
      CMD_INIT: begin
        push_seg(4'h0, 1'b0, 1'b0, POWER_WAIT_US, 1'b0);
        push_seg(4'h3, 1'b0, 1'b0, WAKE_SETUP_US, 1'b0);
        repeat (3) begin
          push_seg(4'h3, 1'b0, 1'b1, STROBE_US, 1'b0);
          push_seg(4'h3, 1'b0, 1'b0, WAKE_GAP_US, 1'b0);
        end
        // switch to four-bit: strobe only, no low phase
        push_seg(4'h2, 1'b0, 1'b1, STROBE_US, 1'b0);
        push_byte(fs_word, 1'b0, 16'd0, 1'b0);
        push_byte(sh_word, 1'b0, 16'd0, 1'b0);
        push_byte(dp_word, 1'b0, 16'd0, 1'b0);
        push_byte(em_word, 1'b0, 16'd0, 1'b0);
        push_byte(LCD_CLEAR, 1'b0, CLEAR_WAIT_US, 1'b1);
        cursor_addr = '0;
      end
      default: ;
    endcase
  endtask

  // ---------------- drivers ----------------

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_cmd(input logic [2:0] cmd, input logic [6:0] adr, input logic [7:0] chr);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, chr, adr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_segments(cmd, adr, chr);
    if (cmd <= CMD_INIT) n_cmds++;
    else n_ignored++;
    if (cmd == CMD_INIT) n_inits++;
  endtask

  // Drop valid, let every predicted segment drain, then allow the block to go idle
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (seg_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input logic [7:0] fs, input logic [7:0] ss,
                               input logic [7:0] ds, input logic [7:0] es);
    logic [7:0] vals [0:3];
    vals[0] = fs;
    vals[1] = ss;
    vals[2] = ds;
    vals[3] = es;
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    fs_word = fs;
    sh_word = ss;
    dp_word = ds;
    em_word = es;
    n_loads++;
  endtask

  function automatic logic [6:0] pick_address();
    logic [6:0] corners [0:7];
    corners[0] = 7'h00;
    corners[1] = ROW0_LAST;
    corners[2] = ROW0_LAST + 7'd1;
    corners[3] = ROW1_FIRST - 7'd1;
    corners[4] = ROW1_FIRST;
    corners[5] = ROW1_LAST;
    corners[6] = ROW1_LAST + 7'd1;
    corners[7] = 7'h7F;
    if ($urandom_range(0, 1) == 0) return 7'($urandom_range(0, 127));
    return corners[$urandom_range(0, 7)];
  endfunction

  task automatic send_random_cmd();
    int r;
    logic [2:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 30) cmd = CMD_WRITE_AT;
    else if (r < 66) cmd = CMD_WRITE_CURSOR;
    else if (r < 74) cmd = CMD_CLEAR;
    else if (r < 82) cmd = CMD_HOME;
    else if (r < 90) cmd = CMD_INIT;
    else cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    send_cmd(cmd, pick_address(), 8'($urandom_range(0, 255)));
  endtask

  // ---------------- tests ----------------

  task automatic run_directed_cases();
    send_cmd(CMD_WRITE_AT, 7'h00, 8'h00);
    send_cmd(CMD_WRITE_AT, 7'h7F, 8'hFF);       // cursor wraps to 0
    send_cmd(CMD_WRITE_CURSOR, 7'h00, 8'hA5);
    send_cmd(CMD_WRITE_AT, ROW0_LAST - 7'd1, 8'h5A);
    send_cmd(CMD_WRITE_CURSOR, 7'h7F, 8'h41);   // last cell of row 0
    send_cmd(CMD_WRITE_CURSOR, 7'h00, 8'h42);   // jumps to row 1
    send_cmd(CMD_WRITE_AT, ROW1_FIRST - 7'd1, 8'h0F);
    send_cmd(CMD_WRITE_CURSOR, 7'h00, 8'hF0);
    send_cmd(CMD_WRITE_AT, ROW1_LAST, 8'h81);
    send_cmd(CMD_WRITE_CURSOR, 7'h55, 8'h7E);   // past row 1: back to home
    send_cmd(CMD_WRITE_AT, ROW0_LAST + 7'd1, 8'h20);
    send_cmd(CMD_WRITE_CURSOR, 7'h00, 8'h33);
    send_cmd(CMD_CLEAR, 7'h7F, 8'hFF);
    send_cmd(CMD_WRITE_CURSOR, 7'h2A, 8'hC3);
    send_cmd(CMD_HOME, 7'h00, 8'h00);
    send_cmd(CMD_UNUSED_LO, 7'h7F, 8'hFF);
    send_cmd(CMD_UNUSED_MID, 7'h2A, 8'h55);
    send_cmd(CMD_UNUSED_HI, 7'h55, 8'hAA);
    send_cmd(CMD_INIT, 7'h00, 8'h00);
    send_cmd(CMD_WRITE_CURSOR, 7'h00, 8'h69);
    send_cmd(CMD_WRITE_AT, 7'h55, 8'h96);
    send_cmd(CMD_HOME, 7'h2A, 8'h3C);
  endtask

  task automatic run_random_traffic(input int n_items);
    int done;
    done = 0;
    while (done < n_items) begin
      // open each phase without any idling on either side
      calm = (done < 15);
      if (in_tuser <= CMD_INIT || done == 0) begin end
      send_random_cmd();
      if (in_tuser <= CMD_INIT) done++;
    end
    calm = 1'b0;
  endtask

  task automatic run_setting_sweep();
    for (int ph = 0; ph < 5; ph++) begin
      settle_block();
      case (ph)
        1: load_settings(8'h00, 8'h00, 8'h00, 8'h00);
        2: load_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        3: load_settings(8'($urandom_range(0, 255)) | 8'h10, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        4: load_settings(8'($urandom_range(0, 255)) & 8'hEF, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        default: ;
      endcase
      send_cmd(CMD_INIT, pick_address(), 8'($urandom_range(0, 255)));
      run_random_traffic(84);
    end
  endtask

  // Hold the output off long enough that the block backs up into its input
  task automatic run_output_hold_off();
    settle_block();
    load_settings(FUNCTION_SET_RST, SHIFT_SET_RST, DISPLAY_SET_RST, ENTRY_SET_RST);
    rx_hold_req = 1'b1;
    while (!rx_holding) @(posedge clk);
    calm = 1'b1;
    repeat (14) send_cmd(CMD_WRITE_CURSOR, pick_address(), 8'($urandom_range(0, 255)));
    send_cmd(CMD_INIT, 7'h00, 8'h00);
    calm = 1'b0;
  endtask

  // ---------------- receiver pacing ----------------

  initial begin : rx_pacing
    int r;
    int len;
    logic lvl;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_holding  = 1'b1;
        lvl = 1'b0;
        len = RX_HOLD_CYCLES;
      end else begin
        rx_holding = 1'b0;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
          lvl = 1'b1;
          len = $urandom_range(1, 8);
        end else if (r < 94) begin
          lvl = 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          lvl = 1'b0;
          len = $urandom_range(10, 40);
        end
      end
      out_tready <= lvl;
      repeat (len) @(posedge clk);
    end
  end

  // ---------------- segment checker ----------------

  always @(posedge clk) begin : seg_check
    lcd_seg_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_segments++;
      if (seg_q.size() == 0) begin
        flag_mismatch("segment with nothing pending, hold_us", int'(out_tdata[22:7]), -1);
      end else begin
        want = seg_q.pop_front();
        if (out_tdata[3:0] !== want.nib)
          flag_mismatch("data_nibble", int'(out_tdata[3:0]), int'(want.nib));
        if (out_tdata[4] !== want.rs)
          flag_mismatch("reg_select", int'(out_tdata[4]), int'(want.rs));
        if (out_tdata[5] !== want.rw)
          flag_mismatch("read_write", int'(out_tdata[5]), int'(want.rw));
        if (out_tdata[6] !== want.en)
          flag_mismatch("enable", int'(out_tdata[6]), int'(want.en));
        if (out_tdata[22:7] !== want.hold)
          flag_mismatch("hold_us", int'(out_tdata[22:7]), int'(want.hold));
        if (out_tlast !== want.last)
          flag_mismatch("last", int'(out_tlast), int'(want.last));
      end
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    if (rst_n && in_tvalid && !in_tready) n_in_stalls++;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d segments pending",
               idle_cycles, seg_q.size());
      $display("char_lcd_nibble_write_sequencer_core: mismatch");
      $finish;
    end
  end

  // ---------------- sequence ----------------

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed_cases();
    run_setting_sweep();
    run_output_hold_off();
    settle_block();
    if (seg_q.size() != 0) flag_mismatch("segments never delivered", 0, seg_q.size());
    $display("Ran %0d commands (%0d inits) plus %0d dropped codes; %0d pin segments checked.",
             n_cmds, n_inits, n_ignored, n_segments);
    $display("Swept %0d register loads incl. all-0/all-1 and 8-bit mode; input stalled %0d cycles.",
             n_loads, n_in_stalls);
    if (n_errors == 0) begin
      $display("char_lcd_nibble_write_sequencer_core: match");
    end else begin
      $display("char_lcd_nibble_write_sequencer_core: mismatch");
    end
    $finish;
  end

endmodule
